@@ rtl/gdd_pkg.sv @@
package gdd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	// day number of year 16383, December 31st, stays below 2^23
	localparam int DN_W    = 23;
	localparam int COUNT_W = 22;
	localparam int DBM_W   = 9;
	localparam int QUOT_W  = 8;
	localparam int NSTAGE  = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

	// days before the 1st of each month, common year; month 0 as January,
	// months 13..15 as December
	localparam logic [DBM_W-1:0] DAYS_BEFORE_MONTH [16] = '{
		9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd334, 9'd334, 9'd334
	};

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_t;

	// floor(x / 100) for x below 16500: multiply by 5243 / 2^19
	function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W:0] x);
		logic [27:0] prod;
		prod = 28'(x) * 28'd5243;
		return prod[26:19];
	endfunction

endpackage

@@ rtl/gregorian_date_difference.sv @@
// Gregorian date difference.
// Slave channel s_axis_*: one transaction carries a pair of dates. The block
// turns each date into a day number (days since a proleptic year zero) and
// returns on the master channel m_axis_* the magnitude of the difference,
// saturated to 22 bits, and a flag in tuser that is set when the first date
// lies strictly before the second. Dates are not checked: out-of-range
// months clamp to January or December, years above MAX_YEAR clamp to it,
// and days run on into neighbouring months.
// Stages from an accepted input to the output register: clamp, divide by
// 100/400 via reciprocal multiply, leap rule and partial sums, day number,
// subtract and compare. Throughput: one transaction per cycle unless the
// receiver stalls; every stage is a register stage of a fully pipelined
// datapath, both dates handled in parallel.
// Reset clears only the stage valid bits, so the output goes quiet at once.
// When the receiver stalls, the stages fill up behind the held result;
// s_axis_tready drops only once every stage holds a transaction, and
// nothing is lost or repeated.
module gregorian_date_difference #(
	parameter int MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_year[13:0], first_month[17:14], first_day[22:18],
	// second_year[36:23], second_month[40:37], second_day[45:41], zero pad
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// day_count[21:0], zero pad
	output logic [23:0] m_axis_tdata,
	// first_earlier
	output logic        m_axis_tuser
);
	import gdd_pkg::*;

	date_t             first_date, second_date;
	logic [NSTAGE-1:0] en;
	logic [DN_W-1:0]   dn_first, dn_second;
	logic [COUNT_W-1:0] day_count;
	logic              first_earlier;

	// unpack the slave payload
	assign first_date.year   = s_axis_tdata[13:0];
	assign first_date.month  = s_axis_tdata[17:14];
	assign first_date.day    = s_axis_tdata[22:18];
	assign second_date.year  = s_axis_tdata[36:23];
	assign second_date.month = s_axis_tdata[40:37];
	assign second_date.day   = s_axis_tdata[45:41];

	// valid chain; each stage advances when it is empty or downstream moves
	gdd_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.en        (en)
	);

	// two identical day-number pipes, stages 1 to 4
	gdd_daynum #(.MAX_YEAR(MAX_YEAR)) u_dn_first (
		.clk     (clk),
		.en      (en[3:0]),
		.date    (first_date),
		.day_num (dn_first)
	);

	gdd_daynum #(.MAX_YEAR(MAX_YEAR)) u_dn_second (
		.clk     (clk),
		.en      (en[3:0]),
		.date    (second_date),
		.day_num (dn_second)
	);

	// stage 5: order and magnitude, also the output register
	gdd_absdiff u_diff (
		.clk           (clk),
		.en            (en[NSTAGE-1]),
		.dn_a          (dn_first),
		.dn_b          (dn_second),
		.day_count     (day_count),
		.first_earlier (first_earlier)
	);

	assign m_axis_tdata = {2'b00, day_count};
	assign m_axis_tuser = first_earlier;

endmodule

@@ rtl/gdd_daynum.sv @@
module gdd_daynum #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                     clk,
	input  logic [3:0]               en,
	input  gdd_pkg::date_t           date,
	output logic [gdd_pkg::DN_W-1:0] day_num
);
	import gdd_pkg::*;

	// s1: clamped year
	logic [YEAR_W-1:0]  y_s1;
	logic [MONTH_W-1:0] m_s1;
	logic [DAY_W-1:0]   d_s1;
	logic [YEAR_W-1:0]  y_sat;

	assign y_sat = ({2'b00, date.year} > 16'(MAX_YEAR)) ? YEAR_W'(MAX_YEAR) : date.year;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			y_s1 <= y_sat;
			m_s1 <= date.month;
			d_s1 <= date.day;
		end
	end

	// s2: constant multiplies and quotients
	logic [YEAR_W-1:0] y_s2;
	logic [DN_W-1:0]   y365_s2;
	logic [YEAR_W-2:0] c4_s2;
	logic [QUOT_W-1:0] q100a_s2, q100y_s2, q400_s2;
	logic [DBM_W-1:0]  dbm_s2;
	logic              late_s2;
	logic [DAY_W-1:0]  d_s2;
	logic [YEAR_W:0]   y_plus3, y_plus99, y_plus399;

	assign y_plus3   = {1'b0, y_s1} + (YEAR_W+1)'(3);
	assign y_plus99  = {1'b0, y_s1} + (YEAR_W+1)'(99);
	assign y_plus399 = {1'b0, y_s1} + (YEAR_W+1)'(399);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			y_s2     <= y_s1;
			y365_s2  <= DN_W'(y_s1) * DN_W'(365);
			c4_s2    <= y_plus3[YEAR_W:2];
			q100a_s2 <= div100(y_plus99);
			q100y_s2 <= div100({1'b0, y_s1});
			q400_s2  <= div100({2'b00, y_plus399[YEAR_W:2]});
			dbm_s2   <= DAYS_BEFORE_MONTH[m_s1];
			late_s2  <= m_s1 > MONTH_FEB;
			d_s2     <= d_s1;
		end
	end

	// s3: leap rule and partial sums
	logic [DN_W-1:0]  base_s3;
	logic [DBM_W-1:0] tail_s3;
	logic             cent, leap;

	assign cent = (YEAR_W'({6'b0, q100y_s2} * 14'd100) == y_s2);
	assign leap = late_s2 & (((y_s2[1:0] == 2'b00) & ~cent) | (cent & (q100y_s2[1:0] == 2'b00)));

	always_ff @(posedge clk) begin
		if (en[2]) begin
			base_s3 <= y365_s2 + DN_W'(c4_s2) - DN_W'(q100a_s2) + DN_W'(q400_s2);
			tail_s3 <= dbm_s2 + DBM_W'(d_s2) + DBM_W'(leap);
		end
	end

	// s4: day number
	logic [DN_W-1:0] dn_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			dn_s4 <= base_s3 + DN_W'(tail_s3);
		end
	end

	assign day_num = dn_s4;

endmodule

@@ rtl/gdd_absdiff.sv @@
module gdd_absdiff (
	input  logic                        clk,
	input  logic                        en,
	input  logic [gdd_pkg::DN_W-1:0]    dn_a,
	input  logic [gdd_pkg::DN_W-1:0]    dn_b,
	output logic [gdd_pkg::COUNT_W-1:0] day_count,
	output logic                        first_earlier
);
	import gdd_pkg::*;

	logic            lt;
	logic [DN_W-1:0] diff;
	logic [COUNT_W-1:0] count_s5;
	logic            earlier_s5;

	assign lt   = dn_a < dn_b;
	assign diff = lt ? (dn_b - dn_a) : (dn_a - dn_b);

	always_ff @(posedge clk) begin
		if (en) begin
			count_s5   <= diff[DN_W-1] ? COUNT_MAX : diff[COUNT_W-1:0];
			earlier_s5 <= lt;
		end
	end

	assign day_count     = count_s5;
	assign first_earlier = earlier_s5;

endmodule

@@ rtl/gdd_pipe_ctl.sv @@
module gdd_pipe_ctl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gdd_pkg::NSTAGE-1:0]   en
);
	import gdd_pkg::*;

	logic [NSTAGE-1:0] v_q;
	logic [NSTAGE-1:0] adv;
	logic [NSTAGE-1:0] v_in;

	// a stage loads when it is empty or its contents move on
	always_comb begin
		adv[NSTAGE-1] = ~v_q[NSTAGE-1] | out_ready;
		for (int k = NSTAGE - 2; k >= 0; k--) begin
			adv[k] = ~v_q[k] | adv[k+1];
		end
	end

	assign v_in = {v_q[NSTAGE-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < NSTAGE; k++) begin
				if (adv[k]) begin
					v_q[k] <= v_in[k];
				end
			end
		end
	end

	assign en        = adv;
	assign in_ready  = adv[0];
	assign out_valid = v_q[NSTAGE-1];

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[2] && !adv[2]) |=> v_q[2])
		else $error("stalled stage lost its transaction");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_q[0])
		else $error("accepted transaction not in first stage");

	a_no_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[3] && adv[3]) |=> v_q[4])
		else $error("transaction dropped between last stages");

endmodule

@@ tb/tb.sv @@
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gdd_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int MAX_YEAR    = 9999;
	// longest receiver hold-off in the fill-and-stall test
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int REPORT_MAX  = 10;

	// expected result of one date pair
	typedef struct packed {
		logic [COUNT_W-1:0] days;
		logic               earlier;
	} span_t;

	logic clk = 1'b0;
	logic arst_n;

	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	span_t pending_spans [$];

	bit src_idling;
	bit sink_idling;
	bit hold_request;

	int pairs_sent;
	int results_seen;
	int earlier_seen;
	int input_stalls;
	int mismatch_count;
	int cycle_count;

	always #(CLK_PERIOD / 2) clk = ~clk;

	gregorian_date_difference #(
		.MAX_YEAR(MAX_YEAR)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// days before the 1st of the month in a common year; month 0 counts as
	// January and 13..15 as December
	function automatic int unsigned month_offset(input logic [MONTH_W-1:0] m);
		case (m)
			4'd0, 4'd1: return 0;
			4'd2:       return 31;
			4'd3:       return 59;
			4'd4:       return 90;
			4'd5:       return 120;
			4'd6:       return 151;
			4'd7:       return 181;
			4'd8:       return 212;
			4'd9:       return 243;
			4'd10:      return 273;
			4'd11:      return 304;
			default:    return 334;
		endcase
	endfunction

	// days since the start of proleptic year zero (year zero is a leap year)
	function automatic longint day_index(input date_t d);
		longint y;
		longint n;
		bit     leap;
		y = d.year;
		if (y > MAX_YEAR)
			y = MAX_YEAR;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		n += month_offset(d.month);
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (d.month > MONTH_FEB && leap)
			n += 1;
		n += d.day;
		return n;
	endfunction

	function automatic span_t predict_span(input date_t first, input date_t second);
		longint a;
		longint b;
		longint diff;
		span_t  s;
		a = day_index(first);
		b = day_index(second);
		diff = (a < b) ? b - a : a - b;
		if (diff > longint'(COUNT_MAX))
			diff = longint'(COUNT_MAX);
		s.days    = diff[COUNT_W-1:0];
		s.earlier = (a < b);
		return s;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic date_t mk(input int y, input int m, input int d);
		date_t r;
		r.year  = y[YEAR_W-1:0];
		r.month = m[MONTH_W-1:0];
		r.day   = d[DAY_W-1:0];
		return r;
	endfunction

	// mostly valid dates, with a share of clamped years, odd months and
	// days running past the month
	function automatic date_t rand_date();
		date_t d;
		int    sel;
		sel = $urandom_range(0, 99);
		if (sel < 72)
			d.year = YEAR_W'($urandom_range(1, MAX_YEAR));
		else if (sel < 82)
			d.year = YEAR_W'($urandom_range(MAX_YEAR + 1, (1 << YEAR_W) - 1));
		else if (sel < 92)
			d.year = YEAR_W'(100 * $urandom_range(0, MAX_YEAR / 100));
		else
			d.year = YEAR_W'($urandom_range(0, 4));
		sel = $urandom_range(0, 99);
		if (sel < 88)
			d.month = MONTH_W'($urandom_range(1, 12));
		else
			d.month = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
		sel = $urandom_range(0, 99);
		if (sel < 80)
			d.day = DAY_W'($urandom_range(1, 28));
		else if (sel < 92)
			d.day = DAY_W'($urandom_range(29, 31));
		else
			d.day = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
		return d;
	endfunction

	// second date: independent, close to the first, identical, or a year off
	function automatic date_t rand_partner(input date_t first);
		date_t d;
		d = first;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: d = rand_date();
			5, 6: d.day = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
			7: d.month = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
			8: ;
			default: d.year = $urandom_range(0, 1) ? YEAR_W'(first.year + 1)
				: YEAR_W'(first.year - 1);
		endcase
		return d;
	endfunction

	// Called at a falling edge, returns at a falling edge with tvalid still
	// high, so back-to-back calls never lower and raise it in one step.
	task automatic send_pair(input date_t first, input date_t second);
		int gap;
		if (src_idling && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, second, first};
		do @(posedge clk); while (!s_axis_tready);
		pending_spans.push_back(predict_span(first, second));
		pairs_sent++;
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending_spans.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_corner_dates();
		send_pair(mk(2024, 5, 17), mk(2024, 5, 17));     // equal: zero, flag clear
		send_pair(mk(1, 1, 1), mk(9999, 12, 31));        // full valid span
		send_pair(mk(9999, 12, 31), mk(1, 1, 1));
		send_pair(mk(0, 1, 1), mk(1, 1, 1));             // year zero, 366 days
		send_pair(mk(0, 2, 28), mk(0, 3, 1));            // year zero is leap
		send_pair(mk(16383, 6, 15), mk(9999, 6, 15));    // year clamps
		send_pair(mk(10000, 1, 1), mk(9999, 1, 1));
		send_pair(mk(2023, 0, 10), mk(2023, 1, 10));     // month zero as January
		send_pair(mk(2023, 15, 1), mk(2023, 12, 1));     // month above twelve
		send_pair(mk(2023, 13, 5), mk(2023, 14, 6));
		send_pair(mk(2023, 3, 0), mk(2023, 2, 28));      // day zero runs back
		send_pair(mk(2023, 2, 31), mk(2023, 3, 3));      // day past month end
		send_pair(mk(2000, 2, 29), mk(2000, 3, 1));      // 400-year leap
		send_pair(mk(1900, 2, 28), mk(1900, 3, 1));      // century, not leap
		send_pair(mk(2100, 3, 1), mk(2096, 3, 1));
		send_pair(mk(2400, 12, 31), mk(2401, 1, 1));
		send_pair(mk(16383, 15, 31), mk(0, 0, 0));       // all ones against zero
		send_pair(mk(0, 0, 0), mk(16383, 15, 31));
		send_pair(mk(9999, 12, 31), mk(9999, 12, 30));
		send_pair(mk(1600, 1, 1), mk(1700, 1, 1));
		send_pair(mk(8191, 7, 16), mk(4096, 8, 15));
		send_pair(mk(4, 2, 29), mk(3, 12, 31));
		wait_all_results();
	endtask

	task automatic test_random_dates(input int n);
		date_t a;
		int    i;
		for (i = 0; i < n; i++) begin
			a = rand_date();
			send_pair(a, rand_partner(a));
		end
		wait_all_results();
	endtask

	// receiver holds off long enough for the pipeline to fill and push back
	// on the input while pairs keep coming
	task automatic test_fill_and_stall();
		date_t a;
		int    i;
		src_idling   = 1'b0;
		hold_request = 1'b1;
		for (i = 0; i < 40; i++) begin
			a = rand_date();
			send_pair(a, rand_partner(a));
		end
		wait_all_results();
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, plus one long hold on request
	// ------------------------------------------------------------------

	initial begin : sink
		int stall_left;
		int held;
		stall_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_axis_tready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_request = 1'b0;
			end else begin
				// a burst never runs on once idling is switched off
				if (!sink_idling)
					stall_left = 0;
				if (stall_left == 0 && sink_idling && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 15);
				if (stall_left > 0) begin
					m_axis_tready <= 1'b0;
					stall_left--;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking, at the rising edge
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		span_t want;
		if (arst_n && s_axis_tvalid && !s_axis_tready)
			input_stalls++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (m_axis_tuser)
				earlier_seen++;
			if (pending_spans.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("ERROR: unexpected result count=%0d earlier=%0b",
						m_axis_tdata[COUNT_W-1:0], m_axis_tuser);
			end else begin
				want = pending_spans.pop_front();
				if (m_axis_tdata[COUNT_W-1:0] !== want.days
						|| m_axis_tuser !== want.earlier
						|| m_axis_tdata[23:COUNT_W] !== '0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display({"ERROR: result %0d: count exp %0d got %0d,",
							" earlier exp %0b got %0b, pad %b"},
							results_seen, want.days, m_axis_tdata[COUNT_W-1:0],
							want.earlier, m_axis_tuser, m_axis_tdata[23:COUNT_W]);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_spans.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		src_idling    = 1'b0;
		sink_idling   = 1'b0;
		hold_request  = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_corner_dates();

		src_idling  = 1'b1;
		sink_idling = 1'b1;
		test_random_dates(900);

		test_fill_and_stall();

		// closing stretch at full rate, no idling on either side
		src_idling  = 1'b0;
		sink_idling = 1'b0;
		test_random_dates(640);

		repeat (NSTAGE + 4) @(negedge clk);

		$display("%0d date pairs sent, %0d results checked (%0d with first date earlier)",
			pairs_sent, results_seen, earlier_seen);
		$display("input held off by the block for %0d cycles, %0d mismatches",
			input_stalls, mismatch_count);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/gdd_pkg.sv
rtl/gdd_daynum.sv
rtl/gdd_absdiff.sv
rtl/gdd_pipe_ctl.sv
rtl/gregorian_date_difference.sv
tb/tb.sv
